// ----- sv/aps_pkg.sv -----
`timescale 1ns / 1ps

package aps_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ACCEPT  = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_SIZE_HI = 2'd0,
    PH_SIZE_LO = 2'd1,
    PH_DATA    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       unit_end;
    logic       last_of_run;
  } out_t;

  // One classified item: an optional unit result followed by an optional verdict.
  typedef struct packed {
    logic       unit_valid;
    logic       unit_is_empty;
    logic [7:0] unit_byte;
    logic       unit_end;
    logic       verdict_valid;
    logic       verdict_accept;
  } cmd_t;

endpackage

// ----- sv/aps_front.sv -----
`timescale 1ns / 1ps

module aps_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  aps_pkg::in_t  in_item,
  input  logic          q_full,
  output logic          full,
  output logic          cmd_push,
  output aps_pkg::cmd_t cmd
);
  import aps_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  size_high_r, size_high_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic        accept;
  logic        boundary;
  logic [15:0] size_w;
  logic [15:0] left_dec;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign size_w   = {size_high_r, in_item.data_byte};
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt      = phase_r;
    size_high_nxt  = size_high_r;
    bytes_left_nxt = bytes_left_r;
    boundary       = 1'b0;
    cmd            = '0;
    unique case (phase_r)
      PH_SIZE_LO: begin
        if (size_w == 16'd0) begin
          cmd.unit_valid    = 1'b1;
          cmd.unit_is_empty = 1'b1;
          cmd.unit_end      = 1'b1;
          phase_nxt         = PH_SIZE_HI;
          boundary          = 1'b1;
        end else begin
          bytes_left_nxt = size_w;
          phase_nxt      = PH_DATA;
        end
      end
      PH_DATA: begin
        bytes_left_nxt = left_dec;
        cmd.unit_valid = 1'b1;
        cmd.unit_byte  = in_item.data_byte;
        cmd.unit_end   = (left_dec == 16'd0);
        if (left_dec == 16'd0) begin
          phase_nxt = PH_SIZE_HI;
          boundary  = 1'b1;
        end
      end
      default: begin
        size_high_nxt = in_item.data_byte;
        phase_nxt     = PH_SIZE_LO;
      end
    endcase
    if (in_item.packet_end) begin
      cmd.verdict_valid  = 1'b1;
      cmd.verdict_accept = boundary;
      phase_nxt          = PH_SIZE_HI;
      size_high_nxt      = 8'd0;
      bytes_left_nxt     = 16'd0;
    end
  end

  assign cmd_push = accept && (cmd.unit_valid || cmd.verdict_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE_HI;
      size_high_r  <= 8'd0;
      bytes_left_r <= 16'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      size_high_r  <= size_high_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

// ----- sv/aps_queue.sv -----
`timescale 1ns / 1ps

module aps_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  aps_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output aps_pkg::cmd_t rd_cmd,
  output logic          q_full,
  output logic          q_empty
);
  import aps_pkg::*;

  cmd_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;
  logic                 do_wr, do_rd;

  assign q_full  = (count_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- sv/aps_back.sv -----
`timescale 1ns / 1ps

module aps_back (
  input  logic          clk,
  input  logic          rst_n,
  input  aps_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output aps_pkg::out_t out_item
);
  import aps_pkg::*;

  out_t out_r, out_nxt;
  logic valid_r;
  logic second_r, second_nxt;
  logic load;

  // The output register takes a new result when it is free or being drained.
  assign load     = !q_empty && (!valid_r || pop);
  assign empty    = !valid_r;
  assign out_item = out_r;

  always_comb begin
    out_nxt    = '0;
    second_nxt = 1'b0;
    q_pop      = 1'b0;
    if (head.unit_valid && !second_r) begin
      out_nxt.kind        = head.unit_is_empty ? KIND_EMPTY : KIND_DATA;
      out_nxt.out_byte    = head.unit_is_empty ? 8'd0 : head.unit_byte;
      out_nxt.unit_end    = head.unit_end;
      out_nxt.last_of_run = !head.verdict_valid;
      second_nxt          = head.verdict_valid;
      q_pop               = load && !head.verdict_valid;
    end else begin
      out_nxt.kind        = head.verdict_accept ? KIND_ACCEPT : KIND_DISCARD;
      out_nxt.last_of_run = 1'b1;
      q_pop               = load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r  <= 1'b1;
        second_r <= second_nxt;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/aggregation_packet_splitter.sv -----
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     push / full          in_item  (data_byte, packet_end)
// result    empty / pop          out_item (kind, out_byte, unit_end, last_of_run)
//
// One input byte is taken per cycle while full is low; full rises only when
// the four-entry queue between the classifier and the output stage is full.
// The output stage sends one result per cycle while pop is high, so a byte with two results
// (a unit byte and a verdict) is sent as two results, the unit result first.
// The first result of a byte is registered in the queue and then in the output register.
// Synchronous active-low reset clears the parser and empties the queue and the output register.
module aggregation_packet_splitter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  aps_pkg::in_t  in_item,
  output logic          empty,
  input  logic          pop,
  output aps_pkg::out_t out_item
);
  import aps_pkg::*;

  cmd_t wr_cmd, head;
  logic cmd_push, q_full, q_empty, q_pop;

  aps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .q_full   (q_full),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd      (wr_cmd)
  );

  aps_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_cmd  (wr_cmd),
    .rd_en   (q_pop),
    .rd_cmd  (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  aps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

// ----- sv/aps_checker.sv -----
`timescale 1ns / 1ps

module aps_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          empty,
  input logic          pop,
  input aps_pkg::out_t out_item
);
  import aps_pkg::*;

  // A waiting result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before pop");

  // Verdicts carry no byte, end no unit and close the byte's results.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.kind == KIND_ACCEPT || out_item.kind == KIND_DISCARD))
    |-> (out_item.out_byte == 8'd0 && !out_item.unit_end && out_item.last_of_run))
    else $error("malformed verdict");

  // An empty-unit marker always ends its unit and carries no byte.
  a_empty_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.kind == KIND_EMPTY)
    |-> (out_item.unit_end && out_item.out_byte == 8'd0))
    else $error("malformed empty-unit marker");

  // A result that is not the last of its byte is followed by that byte's verdict.
  a_run_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_item.last_of_run)
    |=> (empty || out_item.kind == KIND_ACCEPT || out_item.kind == KIND_DISCARD))
    else $error("unit result not followed by verdict");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> empty)
    else $error("result present after reset");

endmodule

bind aggregation_packet_splitter aps_checker u_aps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
